### design/detection_box_decode_top_assert.svh
`ifndef DETECTION_BOX_DECODE_TOP_ASSERT_SVH
`define DETECTION_BOX_DECODE_TOP_ASSERT_SVH

// same-cycle implication
`define DBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dbd_pkg.sv
package dbd_pkg;

  localparam int MAX_CLASSES = 80;

  localparam int VALUE_W     = 16;
  localparam int PIX_W       = 12;
  localparam int CLASS_W     = 8;
  localparam int SCORE_W     = 16;
  localparam int PAD_W       = 12;
  localparam int SCALE_W     = 16;
  localparam int SIZE_W      = 13;
  localparam int COUNT_W     = 8;
  localparam int BOX_IDX_W   = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int FRAC_BITS   = 17;
  localparam int CORNER_W    = 19;
  localparam int PROD_W      = 36;
  localparam int CLAMP_W     = SIZE_W + FRAC_BITS;
  localparam int PROB_W      = 17;
  localparam int TAB_IDX_W   = 8;
  localparam int EXP_TAB_N   = 1 << TAB_IDX_W;
  localparam int OUT_MAX     = 4095;

  localparam logic [CFG_INDEX_W-1:0] REG_PAD_X        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_Y        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam logic [PAD_W-1:0]   PAD_RESET        = '0;
  localparam logic [SCALE_W-1:0] INV_SCALE_RESET  = 16'd4096;
  localparam logic [SIZE_W-1:0]  IMAGE_SIZE_RESET = 13'd640;

  localparam logic [COUNT_W-1:0] BOX_LEN   = 8'd4;
  localparam logic [COUNT_W-1:0] LOGIT_END = COUNT_W'(MAX_CLASSES + 4);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [VALUE_W-1:0] LOGIT_MIN = 16'sh8000;

  typedef struct packed {
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [SCALE_W-1:0] inv_scale;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic signed [VALUE_W-1:0] best_logit;
    logic [CLASS_W-1:0]        best_class;
  } proposal_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] x0;
    logic signed [PROD_W-1:0] x1;
    logic signed [PROD_W-1:0] y0;
    logic signed [PROD_W-1:0] y1;
    logic [CLASS_W-1:0]       class_id;
    logic [SCORE_W-1:0]       score;
  } corners_t;

  function automatic logic [31:0] exp_frac(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:       r = 32'd65536;
      1:       r = 32'd61565;
      2:       r = 32'd57835;
      3:       r = 32'd54331;
      4:       r = 32'd51039;
      5:       r = 32'd47947;
      6:       r = 32'd45042;
      7:       r = 32'd42313;
      8:       r = 32'd39750;
      9:       r = 32'd37341;
      10:      r = 32'd35079;
      11:      r = 32'd32954;
      12:      r = 32'd30957;
      13:      r = 32'd29081;
      14:      r = 32'd27319;
      default: r = 32'd25664;
    endcase
    return r;
  endfunction

  // exp(-mag/16) in Q1.16, elaboration only
  function automatic logic [PROB_W-1:0] exp_q16(input int unsigned mag);
    logic [31:0] e;
    int unsigned n;
    e = exp_frac(mag % 16);
    n = mag / 16;
    for (int unsigned i = 0; i < 16; i++) begin
      if (i < n) begin
        e = (e * 32'd24109 + 32'd32768) >> 16;
      end
    end
    return e[PROB_W-1:0];
  endfunction

  function automatic logic [CLAMP_W-1:0] clamp_corner(input logic signed [PROD_W-1:0] v,
                                                       input logic [SIZE_W-1:0] size);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] r;
    hi = (size == '0) ? '0 : PROD_W'({size - SIZE_W'(1), FRAC_BITS'(0)});
    if (v > hi) begin
      r = hi;
    end else if (v < 0) begin
      r = '0;
    end else begin
      r = v;
    end
    return r[CLAMP_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] to_pixels(input logic [CLAMP_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v[CLAMP_W-1:FRAC_BITS] > SIZE_W'(OUT_MAX)) begin
      r = '1;
    end else begin
      r = v[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
    return r;
  endfunction

endpackage

### design/dbd_in_if.sv
interface dbd_in_if import dbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last_element;

  modport source (output valid, value, last_element, input ready);
  modport sink (input valid, value, last_element, output ready);
endinterface

### design/dbd_out_if.sv
interface dbd_out_if import dbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   box_left;
  logic [PIX_W-1:0]   box_top;
  logic [PIX_W-1:0]   box_width;
  logic [PIX_W-1:0]   box_height;
  logic [CLASS_W-1:0] class_id;
  logic [SCORE_W-1:0] score;

  modport source (output valid, box_left, box_top, box_width, box_height, class_id, score,
                  input ready);
  modport sink (input valid, box_left, box_top, box_width, box_height, class_id, score,
                output ready);
endinterface

### design/dbd_cfg_if.sv
interface dbd_cfg_if import dbd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/dbd_accum.sv
`include "detection_box_decode_top_assert.svh"

module dbd_accum import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dbd_in_if.sink    proposal,
  output logic      prop_valid,
  output proposal_t prop,
  input  logic      prop_ready
);

  logic                      elem_valid;
  logic signed [VALUE_W-1:0] elem_value;
  logic                      elem_last;

  logic [COUNT_W-1:0]        element_count;
  logic signed [VALUE_W-1:0] box_fields [4];
  logic signed [VALUE_W-1:0] best_logit;
  logic [CLASS_W-1:0]        best_class;

  logic signed [VALUE_W-1:0] box_merged [4];
  logic signed [VALUE_W-1:0] best_merged;
  logic [CLASS_W-1:0]        class_merged;

  logic prop_en;
  logic fire;

  assign prop_en        = !prop_valid || prop_ready;
  assign fire           = elem_valid && (!elem_last || prop_en);
  assign proposal.ready = !elem_valid || fire;

  always_comb begin
    box_merged   = box_fields;
    best_merged  = best_logit;
    class_merged = best_class;
    if (element_count < BOX_LEN) begin
      box_merged[element_count[BOX_IDX_W-1:0]] = elem_value;
    end else if (element_count < LOGIT_END && elem_value > best_logit) begin
      best_merged  = elem_value;
      class_merged = CLASS_W'(element_count - BOX_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_valid    <= 1'b0;
      prop_valid    <= 1'b0;
      element_count <= '0;
      box_fields    <= '{default: '0};
      best_logit    <= LOGIT_MIN;
      best_class    <= '0;
    end else begin
      if (proposal.ready) begin
        elem_valid <= proposal.valid;
      end
      if (prop_en) begin
        prop_valid <= fire && elem_last;
      end
      if (fire) begin
        if (elem_last) begin
          element_count <= '0;
          box_fields    <= '{default: '0};
          best_logit    <= LOGIT_MIN;
          best_class    <= '0;
        end else begin
          box_fields <= box_merged;
          best_logit <= best_merged;
          best_class <= class_merged;
          if (element_count != COUNT_MAX) begin
            element_count <= element_count + COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proposal.ready) begin
      elem_value <= proposal.value;
      elem_last  <= proposal.last_element;
    end
    if (fire && elem_last) begin
      prop.cx         <= box_merged[0];
      prop.cy         <= box_merged[1];
      prop.w          <= box_merged[2];
      prop.h          <= box_merged[3];
      prop.best_logit <= best_merged;
      prop.best_class <= class_merged;
    end
  end

  `DBD_ASSERT_NEXT(a_clear_after_last, clk, rst, fire && elem_last,
                   element_count == '0 && best_logit == LOGIT_MIN,
                   "proposal state not cleared after last element")
  `DBD_ASSERT_NOW(a_class_range, clk, rst, 1'b1, best_class < CLASS_W'(MAX_CLASSES),
                  "running argmax class out of range")

endmodule

### design/dbd_scale.sv
module dbd_scale import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      prop_valid,
  input  proposal_t prop,
  output logic      prop_ready,
  input  cfg_regs_t regs,
  output logic      corn_valid,
  output corners_t  corn,
  input  logic      corn_ready
);

  logic [PROB_W-1:0] prob_tab [EXP_TAB_N];

  for (genvar g = 0; g < EXP_TAB_N; g++) begin : g_prob
    localparam longint unsigned DEN  = 64'd65536 + 64'(exp_q16(g));
    localparam longint unsigned PROB = ((64'd1 << 32) + DEN / 2) / DEN;
    assign prob_tab[g] = PROB_W'(PROB);
  end

  logic signed [CORNER_W-1:0] cx_e, cy_e, w_e, h_e, padx_e, pady_e;
  logic signed [CORNER_W-1:0] x0c, x1c, y0c, y1c;
  logic signed [CORNER_W-1:0] scale_e;
  logic [PROB_W-1:0]          logit_u;
  logic [PROB_W-1:0]          mag;
  logic [PROB_W-1:0]          prob;
  logic [SCORE_W-1:0]         score;

  assign prop_ready = !corn_valid || corn_ready;

  assign cx_e    = CORNER_W'(prop.cx);
  assign cy_e    = CORNER_W'(prop.cy);
  assign w_e     = CORNER_W'(prop.w);
  assign h_e     = CORNER_W'(prop.h);
  assign padx_e  = CORNER_W'({regs.pad_x, 5'b0});
  assign pady_e  = CORNER_W'({regs.pad_y, 5'b0});
  assign scale_e = CORNER_W'(regs.inv_scale);

  // corners in 1/32 pixel
  assign x0c = (cx_e <<< 1) - w_e - padx_e;
  assign x1c = (cx_e <<< 1) + w_e - padx_e;
  assign y0c = (cy_e <<< 1) - h_e - pady_e;
  assign y1c = (cy_e <<< 1) + h_e - pady_e;

  assign logit_u = {prop.best_logit[VALUE_W-1], prop.best_logit};
  assign mag     = prop.best_logit[VALUE_W-1] ? (PROB_W'(0) - logit_u) : logit_u;
  assign prob    = (mag < PROB_W'(EXP_TAB_N)) ? prob_tab[mag[TAB_IDX_W-1:0]]
                                               : PROB_W'(65536);

  always_comb begin
    if (prop.best_logit[VALUE_W-1]) begin
      score = SCORE_W'(PROB_W'(65536) - prob);
    end else if (prob[PROB_W-1]) begin
      score = '1;
    end else begin
      score = prob[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corn_valid <= 1'b0;
    end else if (prop_ready) begin
      corn_valid <= prop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prop_valid && prop_ready) begin
      corn.x0       <= PROD_W'(x0c) * PROD_W'(scale_e);
      corn.x1       <= PROD_W'(x1c) * PROD_W'(scale_e);
      corn.y0       <= PROD_W'(y0c) * PROD_W'(scale_e);
      corn.y1       <= PROD_W'(y1c) * PROD_W'(scale_e);
      corn.class_id <= prop.best_class;
      corn.score    <= score;
    end
  end

endmodule

### design/dbd_emit.sv
`include "detection_box_decode_top_assert.svh"

module dbd_emit import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      corn_valid,
  input  corners_t  corn,
  output logic      corn_ready,
  input  cfg_regs_t regs,
  dbd_out_if.source result
);

  logic [CLAMP_W-1:0] x0, x1, y0, y1;
  logic [CLAMP_W:0]   bw, bh;
  logic               keep;

  logic               out_valid;
  logic [PIX_W-1:0]   out_left, out_top, out_width, out_height;
  logic [CLASS_W-1:0] out_class;
  logic [SCORE_W-1:0] out_score;

  assign x0 = clamp_corner(corn.x0, regs.image_width);
  assign x1 = clamp_corner(corn.x1, regs.image_width);
  assign y0 = clamp_corner(corn.y0, regs.image_height);
  assign y1 = clamp_corner(corn.y1, regs.image_height);

  assign bw = {1'b0, x1} - {1'b0, x0};
  assign bh = {1'b0, y1} - {1'b0, y0};

  // need more than one pixel each way; the top bit flags a negative extent
  assign keep = !bw[CLAMP_W] && (bw[CLAMP_W-1:0] > CLAMP_W'(1 << FRAC_BITS)) &&
                !bh[CLAMP_W] && (bh[CLAMP_W-1:0] > CLAMP_W'(1 << FRAC_BITS));

  assign corn_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (corn_ready) begin
      out_valid <= corn_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (corn_valid && corn_ready) begin
      out_left   <= to_pixels(x0);
      out_top    <= to_pixels(y0);
      out_width  <= to_pixels(bw[CLAMP_W-1:0]);
      out_height <= to_pixels(bh[CLAMP_W-1:0]);
      out_class  <= corn.class_id;
      out_score  <= corn.score;
    end
  end

  assign result.valid      = out_valid;
  assign result.box_left   = out_left;
  assign result.box_top    = out_top;
  assign result.box_width  = out_width;
  assign result.box_height = out_height;
  assign result.class_id   = out_class;
  assign result.score      = out_score;

  `DBD_ASSERT_NOW(a_box_nonempty, clk, rst, out_valid,
                  out_width != '0 && out_height != '0,
                  "emitted box has zero extent")

endmodule

### design/detection_box_decode_top.sv
// channel   dir  payload
// proposal  in   value, last_element
// cfg       in   index, data
// result    out  box_left, box_top, box_width, box_height, class_id, score
//
// One element accepted per cycle unless stalled; result stalls ripple back through
// three registered stages (input, proposal, scaled corners) to the result register.
// A proposal's result follows its last element through them and is shown when kept.
// The four corner multipliers (19 x 17 bit) sit in one stage; score comes from a table.
// rst is synchronous: clears the pipeline, proposal state and config to defaults.
// cfg is always ready.
module detection_box_decode_top import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dbd_in_if.sink    proposal,
  dbd_cfg_if.sink   cfg,
  dbd_out_if.source result
);

  cfg_regs_t regs;

  logic      prop_valid;
  proposal_t prop;
  logic      prop_ready;
  logic      corn_valid;
  corners_t  corn;
  logic      corn_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pad_x        <= PAD_RESET;
      regs.pad_y        <= PAD_RESET;
      regs.inv_scale    <= INV_SCALE_RESET;
      regs.image_width  <= IMAGE_SIZE_RESET;
      regs.image_height <= IMAGE_SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PAD_X:        regs.pad_x        <= cfg.data[PAD_W-1:0];
        REG_PAD_Y:        regs.pad_y        <= cfg.data[PAD_W-1:0];
        REG_INV_SCALE:    regs.inv_scale    <= cfg.data[SCALE_W-1:0];
        REG_IMAGE_WIDTH:  regs.image_width  <= cfg.data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: regs.image_height <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  dbd_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .proposal   (proposal),
    .prop_valid (prop_valid),
    .prop       (prop),
    .prop_ready (prop_ready)
  );

  dbd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .prop_valid (prop_valid),
    .prop       (prop),
    .prop_ready (prop_ready),
    .regs       (regs),
    .corn_valid (corn_valid),
    .corn       (corn),
    .corn_ready (corn_ready)
  );

  dbd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .corn_valid (corn_valid),
    .corn       (corn),
    .corn_ready (corn_ready),
    .regs       (regs),
    .result     (result)
  );

endmodule
